[hw/rtl/vsfc_pkg.sv]
// Shared types and constants of the video stream frame checker.
// No dependencies; every other file of the block imports this package.
package vsfc_pkg;

  localparam int REG_W    = 13;
  localparam int CMP_W    = 17;
  localparam int COPIES_W = 13;
  localparam int ERR_W    = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [0:0] REG_LINE_BEATS  = 1'b0;
  localparam logic [0:0] REG_FRAME_LINES = 1'b1;

  localparam logic [ERR_W-1:0] ERR_EOL_EARLY = 3'b001;
  localparam logic [ERR_W-1:0] ERR_EOL_LATE  = 3'b010;
  localparam logic [ERR_W-1:0] ERR_SOF_EARLY = 3'b100;

  typedef struct packed {
    logic [COPIES_W-1:0] copies;
    logic                line_end;
    logic                frame_end;
    logic [ERR_W-1:0]    errors;
  } vsfc_tag_t;

endpackage

[hw/rtl/vsfc_front.sv]
// Front end of the frame checker: accepts beats, tracks line and frame position.
// Holds the configuration registers and writes one result per producing beat to
// the queue. Depends on vsfc_pkg.
module vsfc_front import vsfc_pkg::*; #(
  parameter int BEAT_BITS      = 48,
  parameter int MAX_LINE_BEATS = 4096,
  parameter int MAX_LINES      = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic [BEAT_BITS-1:0] beat_data,
  input  logic                 in_sof,
  input  logic                 in_last,
  output logic                 push,
  output logic [BEAT_BITS-1:0] push_pixel,
  output vsfc_tag_t            push_tag
);

  localparam int COL_W = $clog2(MAX_LINE_BEATS);
  localparam int ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_LINE_BEATS);
  localparam logic [CMP_W-1:0] MAX_H = CMP_W'(MAX_LINES);
  localparam logic [CMP_W-1:0] ONE   = CMP_W'(1);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_LINE,
    PH_DRAIN
  } phase_t;

  phase_t           phase, phase_next;
  logic [COL_W-1:0] column_count, column_count_next, col_base;
  logic [ROW_W-1:0] row_count, row_count_next, row_base;
  logic [ERR_W-1:0] error_bits, error_bits_next, err_base;
  logic [REG_W-1:0] line_beats, frame_lines;
  logic [CMP_W-1:0] width, height, col_ext, row_ext;
  logic             emit;

  always_comb begin
    if (line_beats == '0) begin
      width = ONE;
    end else if (CMP_W'(line_beats) > MAX_W) begin
      width = MAX_W;
    end else begin
      width = CMP_W'(line_beats);
    end
    if (frame_lines == '0) begin
      height = ONE;
    end else if (CMP_W'(frame_lines) > MAX_H) begin
      height = MAX_H;
    end else begin
      height = CMP_W'(frame_lines);
    end
  end

  always_comb begin
    phase_next        = phase;
    column_count_next = column_count;
    row_count_next    = row_count;
    error_bits_next   = error_bits;
    emit              = 1'b0;
    push_pixel        = beat_data;
    push_tag.copies   = COPIES_W'(1);
    push_tag.line_end = 1'b0;
    push_tag.frame_end = 1'b0;
    col_base = (phase == PH_WAIT) ? '0 : column_count;
    row_base = (phase == PH_WAIT) ? '0 : row_count;
    err_base = (phase == PH_WAIT) ? '0 : (error_bits | (in_sof ? ERR_SOF_EARLY : '0));
    col_ext  = CMP_W'(col_base);
    row_ext  = CMP_W'(row_base);
    unique case (phase)
      PH_DRAIN: begin
        error_bits_next = error_bits | ERR_EOL_LATE;
        if (in_last) begin
          if (CMP_W'(row_count) + ONE >= height) begin
            phase_next         = PH_WAIT;
            emit               = 1'b1;
            push_pixel         = '0;
            push_tag.copies    = '0;
            push_tag.frame_end = 1'b1;
          end else begin
            row_count_next    = row_count + ROW_W'(1);
            column_count_next = '0;
            phase_next        = PH_LINE;
          end
        end
      end
      PH_WAIT, PH_LINE: begin
        if (phase == PH_LINE || in_sof) begin
          emit              = 1'b1;
          error_bits_next   = err_base;
          column_count_next = col_base;
          row_count_next    = row_base;
          phase_next        = PH_LINE;
          if (in_last) begin
            push_tag.copies   = (col_ext < width) ? COPIES_W'(width - col_ext)
                                                  : COPIES_W'(1);
            push_tag.line_end = 1'b1;
            if (col_ext + ONE < width) begin
              error_bits_next = err_base | ERR_EOL_EARLY;
            end
            if (row_ext + ONE >= height) begin
              phase_next         = PH_WAIT;
              push_tag.frame_end = 1'b1;
            end else begin
              row_count_next    = row_base + ROW_W'(1);
              column_count_next = '0;
            end
          end else if (col_ext + ONE >= width) begin
            phase_next        = PH_DRAIN;
            push_tag.line_end = 1'b1;
          end else begin
            column_count_next = col_base + COL_W'(1);
          end
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
    push_tag.errors = error_bits_next;
    push = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      column_count <= '0;
      row_count    <= '0;
      error_bits   <= '0;
      line_beats   <= REG_W'(1);
      frame_lines  <= REG_W'(1);
    end else begin
      if (accept) begin
        phase        <= phase_next;
        column_count <= column_count_next;
        row_count    <= row_count_next;
        error_bits   <= error_bits_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LINE_BEATS:  line_beats  <= cfg_data;
          REG_FRAME_LINES: frame_lines <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[hw/rtl/vsfc_queue.sv]
// Short result queue between the front and back ends of the frame checker.
// Register-based FIFO of QUEUE_DEPTH entries. Depends on vsfc_pkg.
module vsfc_queue import vsfc_pkg::*; #(
  parameter int BEAT_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [BEAT_BITS-1:0] push_pixel,
  input  vsfc_tag_t            push_tag,
  input  logic                 pop,
  output logic [BEAT_BITS-1:0] head_pixel,
  output vsfc_tag_t            head_tag,
  output logic                 empty,
  output logic                 full
);

  logic [BEAT_BITS-1:0] pixel_mem [QUEUE_DEPTH];
  vsfc_tag_t            tag_mem   [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [QPTR_W:0]      fill;

  assign empty      = (fill == '0);
  assign full       = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_pixel = pixel_mem[rd_ptr];
  assign head_tag   = tag_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      pixel_mem[wr_ptr] <= push_pixel;
      tag_mem[wr_ptr]   <= push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

[hw/rtl/vsfc_back.sv]
// Back end of the frame checker: moves queued results into the output register.
// Packs the master stream beat. Depends on vsfc_pkg.
module vsfc_back import vsfc_pkg::*; #(
  parameter int BEAT_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [BEAT_BITS-1:0] head_pixel,
  input  vsfc_tag_t            head_tag,
  input  logic                 empty,
  output logic                 pop,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [((BEAT_BITS+COPIES_W+ERR_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser
);

  localparam int OUT_W = ((BEAT_BITS + COPIES_W + ERR_W + 7) / 8) * 8;

  assign pop = !empty && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= OUT_W'({head_tag.errors, head_tag.copies, head_pixel});
      m_axis_tlast <= head_tag.line_end;
      m_axis_tuser <= head_tag.frame_end;
    end
  end

endmodule

[hw/rtl/video_stream_frame_checker.sv]
// Top level of the video stream frame checker: front end, result queue, back end.
// Depends on vsfc_pkg, vsfc_front, vsfc_queue and vsfc_back.
//
// The checker takes one beat per clock and gives at most one result beat per
// input beat, sustaining one beat per cycle in both directions while the master
// side is ready. The front end classifies a beat and writes its result to a
// four-entry queue in the cycle of acceptance; the back end loads it into the
// output register. The slave side stalls only while that queue is full. Beats
// before a start of frame and dropped beats of an over-long line give no result,
// save the frame close at the end of a final line. Configuration writes take
// effect on the next beat and must be made while no results are outstanding.
module video_stream_frame_checker import vsfc_pkg::*; #(
  parameter int BEAT_BITS      = 48,
  parameter int MAX_LINE_BEATS = 4096,
  parameter int MAX_LINES      = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // beat_data
  input  logic [((BEAT_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  // in_sof
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pixel_out, copies, error_flags
  output logic [((BEAT_BITS+COPIES_W+ERR_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  // frame_end
  output logic                 m_axis_tuser
);

  logic                 accept, push, pop, empty, full;
  logic [BEAT_BITS-1:0] push_pixel, head_pixel;
  vsfc_tag_t            push_tag, head_tag;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  vsfc_front #(
    .BEAT_BITS      (BEAT_BITS),
    .MAX_LINE_BEATS (MAX_LINE_BEATS),
    .MAX_LINES      (MAX_LINES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .beat_data  (s_axis_tdata[BEAT_BITS-1:0]),
    .in_sof     (s_axis_tuser),
    .in_last    (s_axis_tlast),
    .push       (push),
    .push_pixel (push_pixel),
    .push_tag   (push_tag)
  );

  vsfc_queue #(
    .BEAT_BITS (BEAT_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pixel (push_pixel),
    .push_tag   (push_tag),
    .pop        (pop),
    .head_pixel (head_pixel),
    .head_tag   (head_tag),
    .empty      (empty),
    .full       (full)
  );

  vsfc_back #(
    .BEAT_BITS (BEAT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_pixel    (head_pixel),
    .head_tag      (head_tag),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result written to a full queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("result taken from an empty queue");

  a_close_beat_shape: assert property (@(posedge clk) disable iff (rst)
    (push && push_tag.copies == '0) |-> (push_tag.frame_end && !push_tag.line_end))
    else $error("zero copy count on a beat that is not a frame close");

  a_output_loaded: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_axis_tvalid)
    else $error("output register not loaded after a queue read");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the video stream frame checker: drives framed beats with
// random idling on both sides and checks every result beat against its own predictor.
// Depends on vsfc_pkg and the video_stream_frame_checker top level.
`timescale 1ns / 1ps

module testbench;
  import vsfc_pkg::*;

  localparam int BEAT_BITS      = 48;
  localparam int MAX_LINE_BEATS = 4096;
  localparam int MAX_LINES      = 4096;
  localparam int IN_W           = ((BEAT_BITS + 7) / 8) * 8;
  localparam int OUT_W          = ((BEAT_BITS + COPIES_W + ERR_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [1:0] {
    AWAIT_SOF,
    IN_LINE,
    DRAINING
  } frame_phase_t;

  typedef struct {
    logic [BEAT_BITS-1:0] pixel;
    logic [COPIES_W-1:0]  copies;
    logic                 line_end;
    logic                 frame_end;
    logic [ERR_W-1:0]     errors;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // beat_data
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  // in_sof
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // pixel_out, copies, error_flags
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  // frame_end
  logic m_axis_tuser;

  logic [REG_W-1:0] line_beats_reg = 1;
  logic [REG_W-1:0] frame_lines_reg = 1;
  frame_phase_t     phase = AWAIT_SOF;
  int               column_count = 0;
  int               row_count = 0;
  logic [ERR_W-1:0] error_bits = '0;

  pixel_result_t pending_results[$];
  int  mismatches = 0;
  int  beats_counted = 0;
  bit  quiet = 1'b0;

  video_stream_frame_checker #(
    .BEAT_BITS(BEAT_BITS),
    .MAX_LINE_BEATS(MAX_LINE_BEATS),
    .MAX_LINES(MAX_LINES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready = quiet ? 1'b1 : ($urandom_range(99) >= 27);
  end

  function automatic int clamp_size(input logic [REG_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [BEAT_BITS-1:0] rand_pixel();
    return BEAT_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [REG_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return REG_W'($urandom_range(1, 6));
    if (roll < 78) return '0;
    if (roll < 90) return REG_W'($urandom_range(7, 40));
    return REG_W'($urandom_range(MAX_LINE_BEATS, (1 << REG_W) - 1));
  endfunction

  task automatic push_result(input logic [BEAT_BITS-1:0] pixel, input int copies,
                             input logic line_end, input logic frame_end);
    pixel_result_t r;
    r.pixel = pixel;
    r.copies = COPIES_W'(copies);
    r.line_end = line_end;
    r.frame_end = frame_end;
    r.errors = error_bits;
    pending_results.push_back(r);
  endtask

  // Advances the frame state by one accepted beat and queues any result it causes.
  task automatic predict_line_result(input logic [BEAT_BITS-1:0] data, input logic sof,
                                     input logic last);
    int w, h, copies;
    w = clamp_size(line_beats_reg, MAX_LINE_BEATS);
    h = clamp_size(frame_lines_reg, MAX_LINES);
    if (!(phase == AWAIT_SOF && !sof)) beats_counted++;
    if (phase == DRAINING) begin
      error_bits |= ERR_EOL_LATE;
      if (last) begin
        if (row_count + 1 >= h) begin
          phase = AWAIT_SOF;
          push_result('0, 0, 1'b0, 1'b1);
        end else begin
          row_count++;
          column_count = 0;
          phase = IN_LINE;
        end
      end
    end else if (phase == IN_LINE || sof) begin
      if (phase == IN_LINE) begin
        if (sof) error_bits |= ERR_SOF_EARLY;
      end else begin
        error_bits = '0;
        row_count = 0;
        column_count = 0;
        phase = IN_LINE;
      end
      if (last) begin
        copies = (column_count < w) ? (w - column_count) : 1;
        if (column_count + 1 < w) error_bits |= ERR_EOL_EARLY;
        if (row_count + 1 >= h) begin
          phase = AWAIT_SOF;
          push_result(data, copies, 1'b1, 1'b1);
        end else begin
          row_count++;
          column_count = 0;
          push_result(data, copies, 1'b1, 1'b0);
        end
      end else if (column_count + 1 >= w) begin
        phase = DRAINING;
        push_result(data, 1, 1'b1, 1'b0);
      end else begin
        column_count++;
        push_result(data, 1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[BEAT_BITS-1:0] !== want.pixel)
          report_mismatch("pixel_out", m_axis_tdata[BEAT_BITS-1:0], want.pixel);
        if (m_axis_tdata[BEAT_BITS +: COPIES_W] !== want.copies)
          report_mismatch("copies", m_axis_tdata[BEAT_BITS +: COPIES_W], want.copies);
        if (m_axis_tdata[BEAT_BITS+COPIES_W +: ERR_W] !== want.errors)
          report_mismatch("error_flags", m_axis_tdata[BEAT_BITS+COPIES_W +: ERR_W],
                          want.errors);
        if (m_axis_tlast !== want.line_end)
          report_mismatch("line_end", m_axis_tlast, want.line_end);
        if (m_axis_tuser !== want.frame_end)
          report_mismatch("frame_end", m_axis_tuser, want.frame_end);
      end
    end
  end

  task automatic send_beat(input logic [BEAT_BITS-1:0] data, input logic sof,
                           input logic last);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 27) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = data;
    s_axis_tuser = sof;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    predict_line_result(data, sof, last);
  endtask

  task automatic settle_block();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(posedge clk);
    if (index == REG_LINE_BEATS) line_beats_reg = value;
    else frame_lines_reg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_pre_frame_drop();
    settle_block();
    write_reg(REG_LINE_BEATS, 3);
    write_reg(REG_FRAME_LINES, 2);
    send_beat('0, 1'b0, 1'b0);
    send_beat('1, 1'b0, 1'b1);
  endtask

  task automatic test_full_and_short_lines();
    send_beat('1, 1'b1, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat('0, 1'b0, 1'b1);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b1);
  endtask

  task automatic test_late_end_of_line();
    settle_block();
    write_reg(REG_LINE_BEATS, 2);
    send_beat(rand_pixel(), 1'b1, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b1, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b1);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b1);
  endtask

  task automatic test_early_start_of_frame();
    settle_block();
    write_reg(REG_LINE_BEATS, 3);
    write_reg(REG_FRAME_LINES, 1);
    send_beat(rand_pixel(), 1'b1, 1'b0);
    send_beat(rand_pixel(), 1'b1, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b1);
  endtask

  task automatic test_register_extremes();
    settle_block();
    write_reg(REG_LINE_BEATS, '1);
    write_reg(REG_FRAME_LINES, '0);
    send_beat('1, 1'b1, 1'b1);
    settle_block();
    write_reg(REG_LINE_BEATS, '0);
    write_reg(REG_FRAME_LINES, '1);
    send_beat(rand_pixel(), 1'b1, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b1);
    settle_block();
    write_reg(REG_LINE_BEATS, REG_W'(MAX_LINE_BEATS));
    write_reg(REG_FRAME_LINES, 1);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat('0, 1'b0, 1'b1);
  endtask

  task automatic test_width_shrink();
    settle_block();
    write_reg(REG_LINE_BEATS, 4);
    write_reg(REG_FRAME_LINES, 2);
    send_beat(rand_pixel(), 1'b1, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    settle_block();
    write_reg(REG_LINE_BEATS, 2);
    send_beat(rand_pixel(), 1'b0, 1'b1);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b0);
    send_beat(rand_pixel(), 1'b0, 1'b1);
  endtask

  // Mostly well-formed frames, with short, long and doubly started lines mixed in.
  task automatic test_random_frames();
    int target, seg, w, h, rows, cols, mode, cut;
    target = beats_counted + 800;
    seg = 0;
    while (beats_counted < target) begin
      settle_block();
      write_reg(REG_LINE_BEATS, pick_size());
      write_reg(REG_FRAME_LINES, pick_size());
      quiet = (seg >= 4 && seg < 8);
      w = clamp_size(line_beats_reg, MAX_LINE_BEATS);
      h = clamp_size(frame_lines_reg, MAX_LINES);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(99) < 8) begin
          repeat ($urandom_range(1, 3)) send_beat(rand_pixel(), 1'b0, 1'($urandom_range(1)));
        end
        rows = (h > 8) ? $urandom_range(1, 3) : h;
        for (int r = 0; r < rows; r++) begin
          mode = $urandom_range(99);
          cut = -1;
          if (w > 40) cols = $urandom_range(1, 4);
          else if (mode < 10 && w > 1) cols = $urandom_range(1, w - 1);
          else if (mode < 20) cols = w + $urandom_range(1, 3);
          else cols = w;
          if (mode >= 20 && mode < 26 && cols > 1) cut = $urandom_range(1, cols - 1);
          for (int c = 0; c < cols; c++) begin
            send_beat(rand_pixel(), (r == 0 && c == 0) || c == cut, c == cols - 1);
          end
        end
      end
      seg++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_pre_frame_drop();
    test_full_and_short_lines();
    test_late_end_of_line();
    test_early_start_of_frame();
    test_register_extremes();
    test_width_shrink();
    test_random_frames();
    settle_block();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/vsfc_pkg.sv
hw/rtl/vsfc_front.sv
hw/rtl/vsfc_queue.sv
hw/rtl/vsfc_back.sv
hw/rtl/video_stream_frame_checker.sv
dv/testbench.sv
